[design/cubemap_box_downsample_assert.svh]
// assertion macros shared by the cubemap downsampler rtl
// no dependencies; included by the modules that carry assertions
`ifndef CUBEMAP_BOX_DOWNSAMPLE_ASSERT_SVH
`define CUBEMAP_BOX_DOWNSAMPLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CBD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cbd_pkg.sv]
// shared types, constants and helpers of the cubemap 2x2 box downsampler
// no dependencies; imported by every module of the block
package cbd_pkg;

    localparam int unsigned CH_W              = 8;
    localparam int unsigned SUM_W             = 9;
    localparam int unsigned FACE_W            = 3;
    localparam int unsigned FACE_COUNT        = 6;
    localparam int unsigned CFG_W             = 10;
    localparam int unsigned CFG_WIDTH_RESET   = 512;
    localparam int unsigned MAX_WIDTH_DEFAULT = 512;
    localparam int unsigned PIX_W             = 4 * CH_W;
    localparam int unsigned USER_W            = 2;
    localparam logic [CH_W-1:0] ALPHA_FULL    = 8'hFF;

    // channel sums of a column pair, red in the lowest bits
    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } sum3_t;

    // where the current beat sits in the face
    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic last_in_face;
        logic last_face;
    } pos_flags_t;

    function automatic sum3_t pack3(input logic [CH_W-1:0] r,
                                    input logic [CH_W-1:0] g,
                                    input logic [CH_W-1:0] b);
        sum3_t s;
        s.red   = SUM_W'(r);
        s.green = SUM_W'(g);
        s.blue  = SUM_W'(b);
        return s;
    endfunction

    // (a + b) >> 2 of two nine-bit partial sums
    function automatic logic [CH_W-1:0] avg4(input logic [SUM_W-1:0] a,
                                             input logic [SUM_W-1:0] b);
        logic [SUM_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[SUM_W:2];
    endfunction

endpackage

[design/cubemap_box_downsample.sv]
// cubemap one-level mip downsampler, 2x2 box filter, rgba8 stream in and out
// an accepted odd-row odd-column beat reaches m_tvalid through the stage-1 and output registers
// throughput: one source beat per cycle sustained, one result per four beats
// input stalls only while a result waits and the next result sits ready behind it
// reset: aresetn low (synchronous) clears positions and valids, width back to 512 capped at MAX_WIDTH
// the line store is not cleared; each entry is written on an even row before an odd row uses it
module cubemap_box_downsample #(
    parameter int unsigned MAX_WIDTH = cbd_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // source pixel beat
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cbd_pkg::PIX_W-1:0]     s_tdata,    // red_in, green_in, blue_in, alpha_in
    // downsampled pixel beat
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cbd_pkg::PIX_W-1:0]     m_tdata,    // red_out, green_out, blue_out, alpha_out
    output logic [cbd_pkg::USER_W-1:0]    m_tuser,    // face_end, cube_end
    // source_width register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbd_pkg::CFG_W-1:0]     cfg_wdata   // source_width
);
    import cbd_pkg::*;

    localparam int unsigned EW     = $clog2(MAX_WIDTH + 1);
    localparam int unsigned SLOT_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH / 2) : 1;
    // reset width, clamped and made even as any written value would be
    localparam int unsigned RESET_W =
        ((CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET) & ~32'd1;

    logic [EW-1:0]     width_reg, width_next;
    logic [31:0]       cfg_wide, cfg_clamped;
    logic              cfg_write;
    logic              load;
    logic [CH_W-1:0]   red_in, green_in, blue_in;
    logic [SLOT_W-1:0] slot;
    pos_flags_t        flags;
    sum3_t             pair_sum_reg;
    sum3_t             pair_now;
    sum3_t             held;

    // the register is always ready; a write restarts the stream at face 0
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // clamp to 2..MAX_WIDTH and drop the lowest bit, so faces are always even
    assign cfg_wide = 32'(cfg_wdata);
    always_comb begin
        priority if (cfg_wide < 32'd2) begin
            cfg_clamped = 32'd2;
        end else if (cfg_wide > 32'(MAX_WIDTH)) begin
            cfg_clamped = 32'(MAX_WIDTH);
        end else begin
            cfg_clamped = cfg_wide;
        end
        width_next = cfg_write ? EW'(cfg_clamped & ~32'd1) : width_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= EW'(RESET_W);
        end else begin
            width_reg <= width_next;
        end
    end

    assign load     = s_tvalid && s_tready;
    assign red_in   = s_tdata[CH_W-1:0];
    assign green_in = s_tdata[2*CH_W-1:CH_W];
    assign blue_in  = s_tdata[3*CH_W-1:2*CH_W];

    cbd_pos_tracker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_write),
        .advance (load),
        .width   (width_reg),
        .slot    (slot),
        .flags   (flags)
    );

    // even column: hold the pixel; odd column: add it to the held one
    always_ff @(posedge aclk) begin
        if (load && !flags.col_odd) begin
            pair_sum_reg <= pack3(red_in, green_in, blue_in);
        end
    end

    assign pair_now.red   = pair_sum_reg.red   + SUM_W'(red_in);
    assign pair_now.green = pair_sum_reg.green + SUM_W'(green_in);
    assign pair_now.blue  = pair_sum_reg.blue  + SUM_W'(blue_in);

    // even rows write the pair sum, odd rows read it back through the registered read port
    cbd_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .aclk  (aclk),
        .wr_en (load && flags.col_odd && !flags.row_odd),
        .rd_en (load),
        .addr  (slot),
        .wdata (pair_now),
        .rdata (held)
    );

    cbd_avg_stage u_avg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .in_ready    (s_tready),
        .emit_in     (flags.col_odd && flags.row_odd),
        .face_end_in (flags.last_in_face),
        .cube_end_in (flags.last_in_face && flags.last_face),
        .pair_in     (pair_now),
        .held_in     (held),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

[design/cbd_pos_tracker.sv]
// column, row and face counters of the source stream, with line store slot
// depends on cbd_pkg and cubemap_box_downsample_assert.svh
`include "cubemap_box_downsample_assert.svh"
module cbd_pos_tracker #(
    parameter int unsigned MAX_WIDTH = cbd_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    restart,
    input  logic                                    advance,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]          width,
    output logic [((MAX_WIDTH > 2) ? $clog2(MAX_WIDTH/2) : 1)-1:0] slot,
    output cbd_pkg::pos_flags_t                     flags
);
    import cbd_pkg::*;

    localparam int unsigned EW     = $clog2(MAX_WIDTH + 1);
    localparam int unsigned POS_W  = $clog2(MAX_WIDTH);
    localparam int unsigned SLOT_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH / 2) : 1;

    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [FACE_W-1:0] face_reg, face_next;
    logic [EW-1:0]     col_inc, row_inc;
    logic              col_wrap, row_wrap;

    assign col_inc  = EW'(col_reg) + EW'(1);
    assign row_inc  = EW'(row_reg) + EW'(1);
    assign col_wrap = (col_inc >= width);
    assign row_wrap = (row_inc >= width);

    assign slot               = SLOT_W'(col_reg >> 1);
    assign flags.col_odd      = col_reg[0];
    assign flags.row_odd      = row_reg[0];
    assign flags.last_in_face = col_wrap && row_wrap;
    assign flags.last_face    = (face_reg == FACE_W'(FACE_COUNT - 1));

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        face_next = face_reg;
        if (restart) begin
            col_next  = '0;
            row_next  = '0;
            face_next = '0;
        end else if (advance) begin
            if (col_wrap) begin
                col_next = '0;
                if (row_wrap) begin
                    row_next  = '0;
                    face_next = flags.last_face ? '0 : face_reg + FACE_W'(1);
                end else begin
                    row_next = POS_W'(row_inc);
                end
            end else begin
                col_next = POS_W'(col_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            face_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            face_reg <= face_next;
        end
    end

    `CBD_ASSERT_NXT(a_face_wraps_to_origin, aclk, aresetn,
        advance && !restart && flags.last_in_face, (col_reg == '0) && (row_reg == '0),
        "position not at origin after last pixel of face")
    `CBD_ASSERT_IMP(a_face_in_range, aclk, aresetn,
        1'b1, face_reg < FACE_W'(FACE_COUNT), "face counter out of range")

endmodule

[design/cbd_line_store.sv]
// line store of even-row column-pair sums, one entry per column pair
// depends on cbd_pkg
module cbd_line_store #(
    parameter int unsigned MAX_WIDTH = cbd_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic                                    rd_en,
    input  logic [((MAX_WIDTH > 2) ? $clog2(MAX_WIDTH/2) : 1)-1:0] addr,
    input  cbd_pkg::sum3_t                          wdata,
    output cbd_pkg::sum3_t                          rdata
);
    import cbd_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH / 2;

    sum3_t mem [DEPTH];
    sum3_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/cbd_avg_stage.sv]
// averaging stage and output register with its handshake
// depends on cbd_pkg and cubemap_box_downsample_assert.svh
`include "cubemap_box_downsample_assert.svh"
module cbd_avg_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    output logic                              in_ready,
    input  logic                              emit_in,
    input  logic                              face_end_in,
    input  logic                              cube_end_in,
    input  cbd_pkg::sum3_t                    pair_in,
    input  cbd_pkg::sum3_t                    held_in,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cbd_pkg::PIX_W-1:0]         m_tdata,
    output logic [cbd_pkg::USER_W-1:0]        m_tuser
);
    import cbd_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_emit_reg;
    logic                s1_face_end_reg;
    logic                s1_cube_end_reg;
    sum3_t               s1_pair_reg;
    logic                out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]    out_data_reg;
    logic [USER_W-1:0]   out_user_reg;
    logic                s1_adv;

    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || m_tready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (load) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_emit_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_emit_reg     <= emit_in;
            s1_face_end_reg <= face_end_in;
            s1_cube_end_reg <= cube_end_in;
            s1_pair_reg     <= pair_in;
        end
        if (s1_adv && s1_emit_reg) begin
            out_data_reg <= {ALPHA_FULL,
                             avg4(held_in.blue,  s1_pair_reg.blue),
                             avg4(held_in.green, s1_pair_reg.green),
                             avg4(held_in.red,   s1_pair_reg.red)};
            out_user_reg <= {s1_cube_end_reg, s1_face_end_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `CBD_ASSERT_IMP(a_no_overwrite, aclk, aresetn,
        s1_adv && s1_emit_reg, !out_valid_reg || m_tready,
        "result overwritten before it was taken")
    `CBD_ASSERT_NXT(a_load_fills_stage, aclk, aresetn,
        load, s1_valid_reg, "accepted beat lost in averaging stage")
    `CBD_ASSERT_NXT(a_drain_clears, aclk, aresetn,
        out_valid_reg && m_tready && !(s1_adv && s1_emit_reg), !out_valid_reg,
        "result repeated after it was taken")
    `CBD_ASSERT_IMP(a_cube_implies_face, aclk, aresetn,
        out_valid_reg && out_user_reg[1], out_user_reg[0],
        "cube end without face end")

endmodule

[test/cubemap_box_downsample_test.sv]
// self-checking bench for the cubemap 2x2 box downsampler: drives source beats and
// width writes, predicts every mip pixel and checks each result beat in order
// depends on cbd_pkg and the cubemap_box_downsample rtl only
module cubemap_box_downsample_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbd_pkg::*;

    localparam int unsigned MAX_WIDTH    = MAX_WIDTH_DEFAULT;
    localparam int unsigned LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned SETTLE_CYCLES = 8;      // output path is two stages deep
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned REPORT_LIMIT = 10;

    // one downsampled pixel as it leaves the block
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            face_end;
        logic            cube_end;
    } mip_pixel_t;

    // width actually used for a register value: clamped to 2..max, forced even
    function automatic int unsigned clamp_width(input logic [CFG_W-1:0] value);
        int unsigned w;
        w = 32'(value);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w - (w % 2);
    endfunction

    // tracks the position in the cube and the column-pair sums, queues the mip
    // pixel that each odd-row odd-column source beat completes
    class mip_scoreboard;
        logic [CFG_W-1:0] width_reg;
        int unsigned      col_pos;
        int unsigned      row_pos;
        int unsigned      face_pos;
        sum3_t            pair_sums;
        sum3_t            line_store [LINE_DEPTH];
        mip_pixel_t       mip_pixels_due [$];
        int unsigned      result_count;
        int unsigned      error_count;

        function new();
            width_reg    = CFG_W'(CFG_WIDTH_RESET);
            result_count = 0;
            error_count  = 0;
            restart();
        endfunction

        function void restart();
            col_pos   = 0;
            row_pos   = 0;
            face_pos  = 0;
            pair_sums = '0;
        endfunction

        function void write_width(input logic [CFG_W-1:0] value);
            width_reg = value;
            restart();
        endfunction

        function int unsigned pending();
            return mip_pixels_due.size();
        endfunction

        function void take_source_pixel(input logic [PIX_W-1:0] beat);
            int unsigned       w;
            int unsigned       slot;
            logic [CH_W-1:0]   r, g, b;
            logic [SUM_W-1:0]  pr, pg, pb;
            logic [SUM_W:0]    total;
            sum3_t             held;
            mip_pixel_t        px;
            w    = clamp_width(width_reg);
            r    = beat[CH_W-1:0];
            g    = beat[2*CH_W-1:CH_W];
            b    = beat[3*CH_W-1:2*CH_W];
            slot = (col_pos / 2) % LINE_DEPTH;
            if (col_pos >= w) col_pos = 0;
            if (row_pos >= w) row_pos = 0;

            if ((col_pos % 2) == 0) begin
                pair_sums.red   = {1'b0, r};
                pair_sums.green = {1'b0, g};
                pair_sums.blue  = {1'b0, b};
            end else begin
                pr = pair_sums.red + SUM_W'(r);
                pg = pair_sums.green + SUM_W'(g);
                pb = pair_sums.blue + SUM_W'(b);
                if ((row_pos % 2) == 0) begin
                    line_store[slot].red   = pr;
                    line_store[slot].green = pg;
                    line_store[slot].blue  = pb;
                end else begin
                    held     = line_store[slot];
                    total    = {1'b0, held.red} + {1'b0, pr};
                    px.red   = total[SUM_W:2];
                    total    = {1'b0, held.green} + {1'b0, pg};
                    px.green = total[SUM_W:2];
                    total    = {1'b0, held.blue} + {1'b0, pb};
                    px.blue  = total[SUM_W:2];
                    px.alpha = ALPHA_FULL;
                    px.face_end = (col_pos == w - 1) && (row_pos == w - 1);
                    px.cube_end = px.face_end && (face_pos == FACE_COUNT - 1);
                    mip_pixels_due.push_back(px);
                end
            end

            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= w) begin
                    row_pos = 0;
                    face_pos++;
                    if (face_pos >= FACE_COUNT) face_pos = 0;
                end
            end
        endfunction

        function void check_mip_pixel(input logic [PIX_W-1:0] data,
                                      input logic [USER_W-1:0] user);
            mip_pixel_t got;
            mip_pixel_t want;
            got.red      = data[CH_W-1:0];
            got.green    = data[2*CH_W-1:CH_W];
            got.blue     = data[3*CH_W-1:2*CH_W];
            got.alpha    = data[4*CH_W-1:3*CH_W];
            got.face_end = user[0];
            got.cube_end = user[1];
            result_count++;
            if (mip_pixels_due.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("mip pixel %0d unexpected: rgba %0d %0d %0d %0d fe %0b ce %0b",
                             result_count, got.red, got.green, got.blue, got.alpha,
                             got.face_end, got.cube_end);
            end else begin
                want = mip_pixels_due.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display(
                            "pixel %0d: want %0d %0d %0d %0d %0b%0b, got %0d %0d %0d %0d %0b%0b",
                            result_count, want.red, want.green, want.blue, want.alpha,
                            want.face_end, want.cube_end, got.red, got.green,
                            got.blue, got.alpha, got.face_end, got.cube_end);
                end
            end
        endfunction
    endclass

    // every block input holds a known value from time zero
    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [PIX_W-1:0]    s_tdata   = '0;      // red_in, green_in, blue_in, alpha_in
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [PIX_W-1:0]    m_tdata;             // red_out, green_out, blue_out, alpha_out
    logic [USER_W-1:0]   m_tuser;             // face_end, cube_end
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_wdata = '0;      // source_width

    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int unsigned         cycle_count   = 0;

    mip_scoreboard sb = new();

    cubemap_box_downsample #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    // 20 ns clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop in case a handshake never completes
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL cubemap_box_downsample");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // beat monitor: all drives are nonblocking, so these are the pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_mip_pixel(m_tdata, m_tuser);
            if (cfg_valid && cfg_ready) sb.write_width(cfg_wdata);
            if (s_tvalid && s_tready) sb.take_source_pixel(s_tdata);
        end
    end

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // one source beat, with a random gap in front; tvalid stays high afterwards
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a, b, g, r};
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait for every predicted pixel, then let the pipeline settle
    // the first edge lets the monitor note the last accepted source beat
    task automatic wait_drained();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // width writes only land on an idle block
    task automatic write_source_width(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : main_seq
        int unsigned      random_sent;
        int unsigned      phase_idx;
        int unsigned      n;
        int unsigned      w;
        int unsigned      face_px;
        int unsigned      faces;
        int unsigned      pick;
        logic [CFG_W-1:0] width_val;
        logic [31:0]      rnd;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        set_idling(31, 86);

        // reset width of 512: first row only, so no result yet
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        send_pixel(8'h80, 8'h7F, 8'h01, 8'hFE);
        s_tvalid <= 1'b0;

        // zero clamps up to the minimum face: all-ones block averages to full scale
        write_source_width(10'd0);
        repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
        s_tvalid <= 1'b0;

        // width one also clamps to two: all-zero block, alpha input ignored
        write_source_width(10'd1);
        repeat (4) send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
        s_tvalid <= 1'b0;

        // odd width rounds down to two; truncation of the sum
        write_source_width(10'd3);
        send_pixel(8'h01, 8'hFF, 8'h02, 8'h55);
        send_pixel(8'h02, 8'hFF, 8'h01, 8'hAA);
        send_pixel(8'h00, 8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFE, 8'h00, 8'hFF);
        s_tvalid <= 1'b0;

        // all register bits set: clamped down to the maximum width
        write_source_width(10'h3FF);
        send_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C);
        send_pixel(8'h5A, 8'hA5, 8'h3C, 8'hC3);
        s_tvalid <= 1'b0;

        // random phases, each after a fresh width write
        random_sent = 0;
        phase_idx   = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3)
                set_idling(31, 86);
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
                set_idling(86, 31);
            else
                set_idling(0, 0);

            pick = $urandom_range(99);
            if (phase_idx == 0 || pick < 6) begin
                // wide face: one even row then part of the odd row
                case ($urandom_range(3))
                    0:       width_val = 10'd512;
                    1:       width_val = 10'd513;
                    2:       width_val = 10'd1023;
                    default: width_val = 10'd700;
                endcase
                write_source_width(width_val);
                n = 512 + 2 * $urandom_range(1, 24);
            end else begin
                width_val = (pick < 75) ? CFG_W'($urandom_range(0, 8))
                                        : CFG_W'($urandom_range(9, 24));
                write_source_width(width_val);
                w       = clamp_width(width_val);
                face_px = w * w;
                if ($urandom_range(99) < 75) begin
                    // whole faces, often past the sixth so the face count wraps
                    faces = $urandom_range(1, 13);
                    while (faces > 1 && faces * face_px > 450) faces--;
                    n = faces * face_px;
                end else begin
                    // cut short anywhere in the face
                    n = $urandom_range(1, 2 * face_px);
                end
            end
            // keep the total close to the planned item count
            if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;

            repeat (n) begin
                rnd = $urandom();
                send_pixel(rnd[7:0], rnd[15:8], rnd[23:16], rnd[31:24]);
            end
            s_tvalid <= 1'b0;
            random_sent += n;
            phase_idx++;
        end

        wait_drained();
        if (sb.pending() != 0)
            $display("%0d mip pixels never arrived", sb.pending());
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("PASS cubemap_box_downsample");
        else
            $display("FAIL cubemap_box_downsample");
        $finish;
    end

endmodule
